### design/qte_pkg.sv
// shared constants, word types and the cordic angle table for the tare and euler block
// no dependencies; compiled first
package qte_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int CORDIC_STEPS   = 16;
    localparam int ANG_TAB_LEN    = 24;
    localparam int CW             = 36;
    localparam int ACC_W          = 32;
    localparam int SQRT_STEPS     = 31;
    localparam int SP_SHIFT       = 30 - 2 * QUAT_FRAC_BITS;
    localparam int PIPE_DEPTH     = 2 + 2 + 2 + SQRT_STEPS + CORDIC_STEPS + 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd3;

    localparam logic signed [15:0] ONE_Q = 16'sd16384;
    localparam logic signed [15:0] HALF_PI = 16'sd16384;

    typedef logic signed [15:0] q16_t;

    typedef struct packed {
        q16_t w;
        q16_t x;
        q16_t y;
        q16_t z;
    } quat_t;

    typedef struct packed {
        quat_t              q;
        logic signed [31:0] sinr;
        logic signed [31:0] cosr;
        logic signed [31:0] siny;
        logic signed [31:0] cosy;
        logic signed [31:0] sp;
        logic               plim_pos;
        logic               plim_neg;
    } terms_t;

    typedef struct packed {
        terms_t      t;
        logic [30:0] c;
    } angin_t;

    typedef struct packed {
        quat_t q;
        q16_t  roll;
        q16_t  pitch;
        q16_t  yaw;
    } euler_t;

    // atan(2^-i) with 2^31 equal to pi
    function automatic logic [ACC_W-1:0] atan_entry(input int unsigned idx);
        logic [ACC_W-1:0] r;
        case (idx)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### design/qte_if.sv
// valid/ready channel interfaces for the raw quaternion word and the result word
// no dependencies
interface qte_raw_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_w;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;

    modport source (output valid, raw_w, raw_x, raw_y, raw_z, input ready);
    modport sink (input valid, raw_w, raw_x, raw_y, raw_z, output ready);
endinterface

interface qte_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] corr_w;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, corr_w, corr_x, corr_y, corr_z, roll_angle, pitch_angle,
                    yaw_angle, input ready);
    modport sink (input valid, corr_w, corr_x, corr_y, corr_z, roll_angle, pitch_angle,
                  yaw_angle, output ready);
endinterface

### design/quaternion_tare_to_euler.sv
// top level: tare offset registers and the tare, terms, sqrt and cordic pipeline
// depends on qte_pkg, qte_if, qte_tare, qte_terms, qte_sqrt, qte_cordic
//
//   channel   dir  handshake          word
//   in_ch     in   valid/ready        raw_w raw_x raw_y raw_z
//   out_ch    out  valid/ready        corr_w..corr_z roll_angle pitch_angle yaw_angle
//   cfg       in   cfg_we             cfg_index, cfg_wdata (offset_w/x/y/z)
//
// one word per cycle sustained while out_ch.ready holds; the pipeline runs through the tare,
// terms, square root (one root bit per stage) and cordic register stages.
// every stage has its own valid bit and load enable, so a stall at the output
// fills the bubbles upstream before in_ch.ready drops.
// reset clears the valid bits and loads the offset with the identity quaternion.
module quaternion_tare_to_euler (
    input  logic                           clk,
    input  logic                           rst_n,
    qte_raw_if.sink                        in_ch,
    qte_res_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [qte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_wdata
);
    import qte_pkg::*;

    quat_t  offset_reg;
    quat_t  raw;
    quat_t  corr;
    terms_t terms;
    angin_t ang;
    euler_t res;
    logic   tr_valid;
    logic   tr_ready;
    logic   tm_valid;
    logic   tm_ready;
    logic   sq_valid;
    logic   sq_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg.w <= ONE_Q;
            offset_reg.x <= '0;
            offset_reg.y <= '0;
            offset_reg.z <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_W: offset_reg.w <= cfg_wdata;
                REG_OFFSET_X: offset_reg.x <= cfg_wdata;
                REG_OFFSET_Y: offset_reg.y <= cfg_wdata;
                REG_OFFSET_Z: offset_reg.z <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign raw.w = in_ch.raw_w;
    assign raw.x = in_ch.raw_x;
    assign raw.y = in_ch.raw_y;
    assign raw.z = in_ch.raw_z;

    qte_tare u_tare (
        .clk       (clk),
        .rst_n     (rst_n),
        .offset    (offset_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .raw       (raw),
        .out_valid (tr_valid),
        .out_ready (tr_ready),
        .corr      (corr)
    );

    qte_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .q         (corr),
        .out_valid (tm_valid),
        .out_ready (tm_ready),
        .terms     (terms)
    );

    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tm_valid),
        .in_ready  (tm_ready),
        .terms     (terms),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .ang       (ang)
    );

    qte_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .ang       (ang),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .res       (res)
    );

    assign out_ch.corr_w      = res.q.w;
    assign out_ch.corr_x      = res.q.x;
    assign out_ch.corr_y      = res.q.y;
    assign out_ch.corr_z      = res.q.z;
    assign out_ch.roll_angle  = res.roll;
    assign out_ch.pitch_angle = res.pitch;
    assign out_ch.yaw_angle   = res.yaw;

endmodule

### design/qte_tare.sv
// hamilton product offset * raw, rounded and saturated, two register stages
// depends on qte_pkg
module qte_tare (
    input  logic          clk,
    input  logic          rst_n,
    input  qte_pkg::quat_t offset,
    input  logic          in_valid,
    output logic          in_ready,
    input  qte_pkg::quat_t raw,
    output logic          out_valid,
    input  logic          out_ready,
    output qte_pkg::quat_t corr
);
    import qte_pkg::*;

    logic               vld_reg [2];
    logic signed [31:0] prod_reg [16];
    logic signed [31:0] prod_next [16];
    quat_t              corr_reg;
    quat_t              corr_next;
    logic               ld0;
    logic               ld1;
    q16_t               raw_a [4];
    q16_t               off_a [4];

    function automatic q16_t rnd_sat(input logic signed [33:0] acc);
        logic signed [33:0] t;
        q16_t               r;
        t = (acc + (34'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
        if (t > 34'(ONE_Q))
            r = ONE_Q;
        else if (t < -34'(ONE_Q))
            r = -ONE_Q;
        else
            r = t[15:0];
        return r;
    endfunction

    function automatic logic signed [33:0] ext(input logic signed [31:0] v);
        return 34'(v);
    endfunction

    assign ld1      = !vld_reg[1] || out_ready;
    assign ld0      = !vld_reg[0] || ld1;
    assign in_ready = ld0;

    always_comb
    begin
        raw_a = '{raw.w, raw.x, raw.y, raw.z};
        off_a = '{offset.w, offset.x, offset.y, offset.z};
        for (int r = 0; r < 4; r++)
        begin
            for (int o = 0; o < 4; o++)
            begin
                prod_next[r*4+o] = 32'(raw_a[r]) * 32'(off_a[o]);
            end
        end
    end

    always_comb
    begin
        corr_next.w = rnd_sat(ext(prod_reg[0]) - ext(prod_reg[5]) - ext(prod_reg[10])
                              - ext(prod_reg[15]));
        corr_next.x = rnd_sat(ext(prod_reg[1]) + ext(prod_reg[4]) - ext(prod_reg[11])
                              + ext(prod_reg[14]));
        corr_next.y = rnd_sat(ext(prod_reg[2]) + ext(prod_reg[7]) + ext(prod_reg[8])
                              - ext(prod_reg[13]));
        corr_next.z = rnd_sat(ext(prod_reg[3]) - ext(prod_reg[6]) + ext(prod_reg[9])
                              + ext(prod_reg[12]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else
        begin
            if (ld0)
                vld_reg[0] <= in_valid;
            if (ld1)
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && in_valid)
            prod_reg <= prod_next;
        if (ld1 && vld_reg[0])
            corr_reg <= corr_next;
    end

    assign out_valid = vld_reg[1];
    assign corr      = corr_reg;

endmodule

### design/qte_terms.sv
// euler sine and cosine terms from the corrected quaternion, two register stages
// depends on qte_pkg
module qte_terms (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qte_pkg::quat_t q,
    output logic           out_valid,
    input  logic           out_ready,
    output qte_pkg::terms_t terms
);
    import qte_pkg::*;

    localparam logic signed [33:0] ONE2 = 34'sd1 <<< (2 * QUAT_FRAC_BITS);

    // wx yz xx yy wy zx wz xy zz
    logic signed [31:0] pr_reg [9];
    logic signed [31:0] pr_next [9];
    quat_t              q_reg;
    terms_t             terms_reg;
    terms_t             terms_next;
    logic               vld_reg [2];
    logic               ld0;
    logic               ld1;
    logic signed [33:0] sinr;
    logic signed [33:0] cosr;
    logic signed [33:0] sinp;
    logic signed [33:0] siny;
    logic signed [33:0] cosy;

    assign ld1      = !vld_reg[1] || out_ready;
    assign ld0      = !vld_reg[0] || ld1;
    assign in_ready = ld0;

    always_comb
    begin
        pr_next[0] = 32'(q.w) * 32'(q.x);
        pr_next[1] = 32'(q.y) * 32'(q.z);
        pr_next[2] = 32'(q.x) * 32'(q.x);
        pr_next[3] = 32'(q.y) * 32'(q.y);
        pr_next[4] = 32'(q.w) * 32'(q.y);
        pr_next[5] = 32'(q.z) * 32'(q.x);
        pr_next[6] = 32'(q.w) * 32'(q.z);
        pr_next[7] = 32'(q.x) * 32'(q.y);
        pr_next[8] = 32'(q.z) * 32'(q.z);
    end

    always_comb
    begin
        sinr = (34'(pr_reg[0]) + 34'(pr_reg[1])) <<< 1;
        cosr = ONE2 - ((34'(pr_reg[2]) + 34'(pr_reg[3])) <<< 1);
        sinp = (34'(pr_reg[4]) - 34'(pr_reg[5])) <<< 1;
        siny = (34'(pr_reg[6]) + 34'(pr_reg[7])) <<< 1;
        cosy = ONE2 - ((34'(pr_reg[3]) + 34'(pr_reg[8])) <<< 1);
        terms_next.q        = q_reg;
        terms_next.sinr     = sinr[31:0];
        terms_next.cosr     = cosr[31:0];
        terms_next.siny     = siny[31:0];
        terms_next.cosy     = cosy[31:0];
        terms_next.plim_pos = sinp >= ONE2;
        terms_next.plim_neg = sinp <= -ONE2;
        // only meaningful when not at the pitch limit
        terms_next.sp       = 32'(sinp <<< SP_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else
        begin
            if (ld0)
                vld_reg[0] <= in_valid;
            if (ld1)
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && in_valid)
        begin
            pr_reg <= pr_next;
            q_reg  <= q;
        end
        if (ld1 && vld_reg[0])
            terms_reg <= terms_next;
    end

    assign out_valid = vld_reg[1];
    assign terms     = terms_reg;

endmodule

### design/qte_sqrt.sv
// cosine of pitch as floor(sqrt(2^60 - s^2)), one root bit per register stage
// depends on qte_pkg
module qte_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qte_pkg::terms_t terms,
    output logic            out_valid,
    input  logic            out_ready,
    output qte_pkg::angin_t ang
);
    import qte_pkg::*;

    localparam int NS = SQRT_STEPS + 2;
    localparam logic [61:0] RAD_ONE = 62'(1) << 60;

    logic        vld_reg  [NS];
    terms_t      pay_reg  [NS];
    logic [61:0] rem_reg  [NS];
    logic [61:0] root_reg [NS];
    logic [61:0] rem_next [NS];
    logic [61:0] root_next [NS];
    logic        ld [NS];
    logic [63:0] sq;

    // ready chain from the output back to the input
    always_comb
    begin
        ld[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            ld[s] = !vld_reg[s] || ld[s+1];
        end
    end
    assign in_ready = ld[0];

    always_comb
    begin
        logic [61:0] bitv;
        logic [61:0] trial;
        sq           = 64'(terms.sp) * 64'(terms.sp);
        rem_next[0]  = sq[61:0];
        root_next[0] = '0;
        rem_next[1]  = RAD_ONE - rem_reg[0];
        root_next[1] = '0;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bitv  = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
            trial = root_reg[k+1] + bitv;
            if (rem_reg[k+1] >= trial)
            begin
                rem_next[k+2]  = rem_reg[k+1] - trial;
                root_next[k+2] = (root_reg[k+1] >> 1) + bitv;
            end
            else
            begin
                rem_next[k+2]  = rem_reg[k+1];
                root_next[k+2] = root_reg[k+1] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (ld[s])
                    vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0] && in_valid)
        begin
            pay_reg[0]  <= terms;
            rem_reg[0]  <= rem_next[0];
            root_reg[0] <= root_next[0];
        end
        for (int s = 1; s < NS; s++)
        begin
            if (ld[s] && vld_reg[s-1])
            begin
                pay_reg[s]  <= pay_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign ang.t     = pay_reg[NS-1];
    assign ang.c     = root_reg[NS-1][30:0];

endmodule

### design/qte_cordic.sv
// three-lane vectoring cordic for roll, pitch and yaw, one rotation per stage
// depends on qte_pkg
module qte_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qte_pkg::angin_t ang,
    output logic            out_valid,
    input  logic            out_ready,
    output qte_pkg::euler_t res
);
    import qte_pkg::*;

    localparam int NC = CORDIC_STEPS + 2;
    localparam int LROLL = 0;
    localparam int LPITCH = 1;
    localparam int LYAW = 2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ACC_W-1:0]     acc;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] ln;
        quat_t       q;
        logic        plim_pos;
        logic        plim_neg;
    } cst_t;

    logic   vld_reg [NC];
    logic   ld [NC];
    cst_t   st_reg  [CORDIC_STEPS+1];
    cst_t   st_next [CORDIC_STEPS+1];
    euler_t res_reg;
    euler_t res_next;

    function automatic lane_t prep(input logic signed [CW-1:0] yv,
                                   input logic signed [CW-1:0] xv);
        lane_t l;
        l.zero = (xv == '0) && (yv == '0);
        if (xv < 0)
        begin
            l.x   = -xv;
            l.y   = -yv;
            l.acc = 32'h8000_0000;
        end
        else
        begin
            l.x   = xv;
            l.y   = yv;
            l.acc = '0;
        end
        return l;
    endfunction

    function automatic lane_t rot(input lane_t l, input int unsigned i);
        lane_t                r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        r  = l;
        // clockwise while y is non-negative
        if (!l.y[CW-1])
        begin
            r.x   = l.x + dx;
            r.y   = l.y - dy;
            r.acc = l.acc + atan_entry(i);
        end
        else
        begin
            r.x   = l.x - dx;
            r.y   = l.y + dy;
            r.acc = l.acc - atan_entry(i);
        end
        return r;
    endfunction

    function automatic q16_t to_bam(input lane_t l);
        logic [ACC_W-1:0] a;
        a = l.acc + 32'h0000_8000;
        return l.zero ? '0 : q16_t'(a[31:16]);
    endfunction

    always_comb
    begin
        ld[NC-1] = !vld_reg[NC-1] || out_ready;
        for (int s = NC - 2; s >= 0; s--)
        begin
            ld[s] = !vld_reg[s] || ld[s+1];
        end
    end
    assign in_ready = ld[0];

    always_comb
    begin
        q16_t p;
        st_next[0].q         = ang.t.q;
        st_next[0].plim_pos  = ang.t.plim_pos;
        st_next[0].plim_neg  = ang.t.plim_neg;
        st_next[0].ln[LROLL] = prep(CW'(ang.t.sinr), CW'(ang.t.cosr));
        st_next[0].ln[LPITCH] = prep(CW'(ang.t.sp), CW'({1'b0, ang.c}));
        st_next[0].ln[LYAW]  = prep(CW'(ang.t.siny), CW'(ang.t.cosy));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            st_next[i+1] = st_reg[i];
            for (int n = 0; n < 3; n++)
                st_next[i+1].ln[n] = rot(st_reg[i].ln[n], i);
        end
        res_next.q    = st_reg[CORDIC_STEPS].q;
        res_next.roll = to_bam(st_reg[CORDIC_STEPS].ln[LROLL]);
        res_next.yaw  = to_bam(st_reg[CORDIC_STEPS].ln[LYAW]);
        p = to_bam(st_reg[CORDIC_STEPS].ln[LPITCH]);
        if (st_reg[CORDIC_STEPS].plim_pos)
            res_next.pitch = HALF_PI;
        else if (st_reg[CORDIC_STEPS].plim_neg)
            res_next.pitch = -HALF_PI;
        else if (p > HALF_PI)
            res_next.pitch = HALF_PI;
        else if (p < -HALF_PI)
            res_next.pitch = -HALF_PI;
        else
            res_next.pitch = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NC; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int s = 1; s < NC; s++)
            begin
                if (ld[s])
                    vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0] && in_valid)
            st_reg[0] <= st_next[0];
        for (int s = 1; s <= CORDIC_STEPS; s++)
        begin
            if (ld[s] && vld_reg[s-1])
                st_reg[s] <= st_next[s];
        end
        if (ld[NC-1] && vld_reg[NC-2])
            res_reg <= res_next;
    end

    assign out_valid = vld_reg[NC-1];
    assign res       = res_reg;

endmodule

### design/qte_checker.sv
// port-level checks on the tare and euler block, attached by bind
// depends on qte_pkg and quaternion_tare_to_euler
module qte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] corr_w,
    input logic signed [15:0] pitch_angle,
    input logic signed [15:0] roll_angle
);
    import qte_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // words in flight
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
            cnt_next = cnt_next + CNT_W'(1);
        if (out_valid && out_ready)
            cnt_next = cnt_next - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corr_w) && $stable(roll_angle))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result word with no input in flight");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> cnt_reg != '0)
        else $error("input stalled with empty pipeline");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_angle >= -16'sd16384 && pitch_angle <= 16'sd16384
                      && corr_w >= -16'sd16384 && corr_w <= 16'sd16384)
        else $error("pitch or corrected component out of range");

endmodule

bind quaternion_tare_to_euler qte_checker u_qte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .corr_w      (out_ch.corr_w),
    .pitch_angle (out_ch.pitch_angle),
    .roll_angle  (out_ch.roll_angle)
);

### test/qte_tb_if.sv
// types for the testbench: the euler result word; the block's channel interfaces are reused
// no dependencies
package qte_tb_types;
    typedef struct {
        logic signed [15:0] w, x, y, z, roll, pitch, yaw;
    } euler_word_t;
endpackage

### test/tb.sv
// testbench for quaternion_tare_to_euler: random and directed raw quaternions under
// several tare offsets, results checked against an in-bench predictor
// depends on qte_pkg, qte_if, qte_tb_if and the block
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qte_pkg::*;
    import qte_tb_types::*;

    class euler_scoreboard;
        longint ow, ox, oy, oz;
        euler_word_t pending[$];
        int errors;

        function new();
            ow = 16384; ox = 0; oy = 0; oz = 0; errors = 0;
        endfunction

        function void set_offset(logic [1:0] idx, logic signed [15:0] v);
            case (idx)
                REG_OFFSET_W: ow = v;
                REG_OFFSET_X: ox = v;
                REG_OFFSET_Y: oy = v;
                default: oz = v;
            endcase
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint round_sat(longint acc);
            longint v;
            v = floor_shr(acc + 8192, QUAT_FRAC_BITS);
            if (v > 16384) v = 16384;
            if (v < -16384) v = -16384;
            return v;
        endfunction

        function longint vector_angle(longint yv, longint xv);
            logic [31:0] acc;
            longint dx, dy;
            logic [31:0] t;
            acc = 0;
            if (xv == 0 && yv == 0) return 0;
            while ((xv < 0 ? -xv : xv) >= (64'sd1 <<< 40) || (yv < 0 ? -yv : yv) >= (64'sd1 <<< 40))
            begin
                xv = xv >>> 1;
                yv = yv >>> 1;
            end
            if (xv < 0)
            begin
                xv = -xv;
                yv = -yv;
                acc = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (yv >= 0)
                begin
                    xv += dx; yv -= dy; acc += atan_table(i);
                end
                else
                begin
                    xv -= dx; yv += dy; acc -= atan_table(i);
                end
            end
            t = acc + 32'h8000;
            return longint'($signed(t[31:16]));
        endfunction

        function logic [31:0] atan_table(int i);
            logic [31:0] tab [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
            return tab[i];
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function longint pitch_from_sin(longint sinp);
            longint s, p;
            if (sinp >= (64'sd1 <<< 28)) return 16384;
            if (sinp <= -(64'sd1 <<< 28)) return -16384;
            s = sinp * 4;
            p = vector_angle(s, int_sqrt((64'd1 << 60) - longint'(s * s)));
            if (p > 16384) p = 16384;
            if (p < -16384) p = -16384;
            return p;
        endfunction

        function void note_raw(logic signed [15:0] rw, rx, ry, rz);
            longint w, x, y, z, a, b, c, d;
            euler_word_t e;
            a = rw; b = rx; c = ry; d = rz;
            w = round_sat(a * ow - b * ox - c * oy - d * oz);
            x = round_sat(a * ox + b * ow - c * oz + d * oy);
            y = round_sat(a * oy + b * oz + c * ow - d * ox);
            z = round_sat(a * oz - b * oy + c * ox + d * ow);
            e.w = w; e.x = x; e.y = y; e.z = z;
            e.roll = vector_angle(2 * (w * x + y * z), (64'sd1 <<< 28) - 2 * (x * x + y * y));
            e.pitch = pitch_from_sin(2 * (w * y - z * x));
            e.yaw = vector_angle(2 * (w * z + x * y), (64'sd1 <<< 28) - 2 * (y * y + z * z));
            pending.push_back(e);
        endfunction

        function void check_result(euler_word_t got);
            euler_word_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word: got %p", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t mismatch: expected %p actual %p", $realtime, e, got);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_wdata;
    int src_idle, snk_idle;
    euler_scoreboard board;

    qte_raw_if in_ch();
    qte_res_if out_ch();

    quaternion_tare_to_euler dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_result('{out_ch.corr_w, out_ch.corr_x, out_ch.corr_y, out_ch.corr_z,
                    out_ch.roll_angle, out_ch.pitch_angle, out_ch.yaw_angle});
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    function logic signed [15:0] edge_val();
        case ($urandom_range(5))
            0: return 16384;
            1: return -16384;
            2: return 0;
            3: return 16'(-$urandom_range(16384));
            4: return 16'($urandom);
            default: return 16'($urandom_range(16384));
        endcase
    endfunction

    task automatic send_raw(logic signed [15:0] w, x, y, z);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.raw_w <= w; in_ch.raw_x <= x; in_ch.raw_y <= y; in_ch.raw_z <= z;
        do @(posedge clk); while (!in_ch.ready);
        board.note_raw(w, x, y, z);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // the enable drops after each write so back to back writes never collide
    task automatic write_offset(logic [CFG_IDX_W-1:0] idx, logic signed [15:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.set_offset(idx, v);
        @(posedge clk);
    endtask

    task automatic random_tare();
        write_offset(REG_OFFSET_W, edge_val());
        write_offset(REG_OFFSET_X, edge_val());
        write_offset(REG_OFFSET_Y, edge_val());
        write_offset(REG_OFFSET_Z, edge_val());
    endtask

    initial
    begin
        board = new();
        rst_n = 0; cfg_we = 0; cfg_index = REG_OFFSET_W; cfg_wdata = 0;
        in_ch.valid = 0; in_ch.raw_w = 0; in_ch.raw_x = 0; in_ch.raw_y = 0; in_ch.raw_z = 0;
        out_ch.ready = 0;
        src_idle = 6; snk_idle = 52;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // identity tare: extremes, zero vector, gimbal lock, out of range patterns
        send_raw(16384, 0, 0, 0);
        send_raw(-16384, 0, 0, 0);
        send_raw(0, 0, 0, 0);
        send_raw(11585, 0, 11585, 0);
        send_raw(11585, 0, -11585, 0);
        send_raw(0, 16384, 0, 0);
        send_raw(0, 0, 0, 16384);
        send_raw(0, 0, 16384, 0);
        send_raw(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_raw(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_raw(-1, -1, -1, -1);
        send_raw(8192, -8192, 8192, -8192);
        drain();
        // conjugate tare of a reading
        write_offset(REG_OFFSET_W, 11585);
        write_offset(REG_OFFSET_X, -11585);
        write_offset(REG_OFFSET_Y, 0);
        write_offset(REG_OFFSET_Z, 0);
        send_raw(11585, 11585, 0, 0);
        send_raw(16384, 0, 0, 0);
        send_raw(0, 0, 16384, 0);
        drain();
        write_offset(REG_OFFSET_W, 16'sh8000);
        write_offset(REG_OFFSET_X, 16'sh7fff);
        write_offset(REG_OFFSET_Y, -16384);
        write_offset(REG_OFFSET_Z, 16384);
        send_raw(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_raw(16384, 16384, 16384, 16384);
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3) begin src_idle = 52; snk_idle = 6; end
            if (ph == 6) begin src_idle = 0; snk_idle = 0; end
            if (ph == 0)
            begin
                write_offset(REG_OFFSET_W, 16384);
                write_offset(REG_OFFSET_X, 0);
                write_offset(REG_OFFSET_Y, 0);
                write_offset(REG_OFFSET_Z, 0);
            end
            else
                random_tare();
            for (int n = 0; n < 50; n++)
                send_raw(edge_val(), edge_val(), edge_val(), edge_val());
            drain();
        end
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### quaternion_tare_to_euler.f
design/qte_pkg.sv
design/qte_if.sv
design/qte_tare.sv
design/qte_terms.sv
design/qte_sqrt.sv
design/qte_cordic.sv
design/quaternion_tare_to_euler.sv
design/qte_checker.sv
test/qte_tb_if.sv
test/tb.sv
